/* design/bpnsm_pkg.sv */
`timescale 1ns / 1ps
package bpnsm_pkg;

  localparam int unsigned ProcW  = 16;
  localparam int unsigned NodeW  = 13;
  localparam int unsigned SlotsW = 22;
  localparam int unsigned AllocW = 10;
  localparam int unsigned LagW   = 17;
  localparam int unsigned IdxW   = 2;

  localparam logic [LagW-1:0] LAG_MAX = {LagW{1'b1}};

  localparam logic [IdxW-1:0] REG_TOTAL_PROCS      = 2'd0;
  localparam logic [IdxW-1:0] REG_NODE_COUNT       = 2'd1;
  localparam logic [IdxW-1:0] REG_TOTAL_SLOTS      = 2'd2;
  localparam logic [IdxW-1:0] REG_NO_OVERSUBSCRIBE = 2'd3;

  typedef logic [ProcW-1:0]  proc_t;
  typedef logic [NodeW-1:0]  node_t;
  typedef logic [SlotsW-1:0] slots_t;
  typedef logic [AllocW-1:0] alloc_t;
  typedef logic [LagW-1:0]   lag_t;
  typedef logic [IdxW-1:0]   reg_idx_t;

  typedef struct packed {
    alloc_t slots_allocated;
    alloc_t slots_used;
    proc_t  procs_present;
  } item_t;

  typedef struct packed {
    proc_t  assigned_count;
    logic   node_oversubscribed;
    logic   job_done;
    logic   status;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic  start;
    proc_t dividend;
    node_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    proc_t quotient;
    node_t remainder;
  } div_rsp_t;

endpackage

/* design/bpnsm_if.sv */
`timescale 1ns / 1ps
interface bpnsm_in_if;
  logic                   valid;
  logic                   ready;
  bpnsm_pkg::alloc_t      slots_allocated;
  bpnsm_pkg::alloc_t      slots_used;
  bpnsm_pkg::proc_t       procs_present;

  modport source(output valid, slots_allocated, slots_used, procs_present, input ready);
  modport sink(input valid, slots_allocated, slots_used, procs_present, output ready);
endinterface

interface bpnsm_out_if;
  logic                   valid;
  logic                   ready;
  bpnsm_pkg::proc_t       assigned_count;
  logic                   node_oversubscribed;
  logic                   job_done;
  logic                   status;

  modport source(output valid, assigned_count, node_oversubscribed, job_done, status,
                 input ready);
  modport sink(input valid, assigned_count, node_oversubscribed, job_done, status,
               output ready);
endinterface

interface bpnsm_cfg_if;
  logic                   valid;
  logic                   ready;
  bpnsm_pkg::reg_idx_t    reg_index;
  bpnsm_pkg::slots_t      data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

/* design/balanced_per_node_share_mapper_top.sv */
`timescale 1ns / 1ps
// Balanced per-node share mapper.
// Node records enter on in_chan, one transfer per node, and one result per
// node leaves on out_chan in the same order. Job registers are written on
// cfg_chan (index 0 total_procs, 1 node_count, 2 total_slots,
// 3 no_oversubscribe); cfg_chan is always ready. The user must write them
// only while no node is in flight; the block itself does not enforce it.
// A two-entry queue takes node records while the placement engine works.
// The engine dequeues a node in S_IDLE, then computes its result in S_CALC
// and loads the output register; only then does it take the next node.
// The first node of a job also waits in S_DIV while a bit-serial division
// of total_procs by node_count sets the average share and remainder.
// When out_chan is stalled the result holds in the output register, the
// engine waits, and the queue keeps accepting until both entries are full.
// Synchronous reset (rst_n low) empties the queue and the output register,
// clears the job progress and loads total_procs=1, node_count=1,
// total_slots=0 and no_oversubscribe=0.
module balanced_per_node_share_mapper_top (
  input logic         clk,
  input logic         rst_n,
  bpnsm_in_if.sink    in_chan,
  bpnsm_out_if.source out_chan,
  bpnsm_cfg_if.sink   cfg_chan
);
  import bpnsm_pkg::*;

  item_t       in_item;
  queue_head_t head;
  logic        pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  result_t     out_res;

  assign in_item.slots_allocated = in_chan.slots_allocated;
  assign in_item.slots_used      = in_chan.slots_used;
  assign in_item.procs_present   = in_chan.procs_present;
  assign cfg_chan.ready          = 1'b1;

  assign out_chan.assigned_count      = out_res.assigned_count;
  assign out_chan.node_oversubscribed = out_res.node_oversubscribed;
  assign out_chan.job_done            = out_res.job_done;
  assign out_chan.status              = out_res.status;

  bpnsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  bpnsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bpnsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.reg_index),
    .cfg_data  (cfg_chan.data),
    .head      (head),
    .pop       (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

endmodule

/* design/bpnsm_front.sv */
`timescale 1ns / 1ps
module bpnsm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bpnsm_pkg::item_t       in_item,
  output bpnsm_pkg::queue_head_t head,
  input  logic                   pop
);
  import bpnsm_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       do_pop;

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* design/bpnsm_div.sv */
`timescale 1ns / 1ps
module bpnsm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  bpnsm_pkg::div_req_t req,
  output bpnsm_pkg::div_rsp_t rsp
);
  import bpnsm_pkg::*;

  localparam int unsigned CntW = $clog2(ProcW);

  logic              busy_r;
  logic              done_r;
  logic [CntW-1:0]   cnt_r;
  proc_t             q_r;
  node_t             rem_r;
  node_t             d_r;
  logic [NodeW:0]    trial;
  logic [NodeW:0]    diff;
  logic              fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, q_r[ProcW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign fits  = (trial >= {1'b0, d_r});

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      d_r   <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[ProcW-2:0], fits};
      rem_r <= fits ? diff[NodeW-1:0] : trial[NodeW-1:0];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == CntW'(ProcW - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(ProcW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

/* design/bpnsm_back.sv */
`timescale 1ns / 1ps
module bpnsm_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  bpnsm_pkg::reg_idx_t    cfg_index,
  input  bpnsm_pkg::slots_t      cfg_data,
  input  bpnsm_pkg::queue_head_t head,
  output logic                   pop,
  output bpnsm_pkg::div_req_t    div_req,
  input  bpnsm_pkg::div_rsp_t    div_rsp,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bpnsm_pkg::result_t     out_res
);
  import bpnsm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CALC} state_t;

  state_t  state_r;
  proc_t   total_procs_r;
  node_t   node_count_r;
  slots_t  total_slots_r;
  logic    no_over_r;

  item_t   item_r;
  logic    started_r;
  proc_t   avg_r;
  node_t   enl_r;
  logic    es_r;
  lag_t    lag_r;
  proc_t   placed_r;

  logic    out_valid_r;
  result_t out_res_r;

  logic    over;
  logic    blocked;
  logic    finished;
  logic    need_div;
  logic    slot_free;

  proc_t   avg;
  node_t   enl;
  logic    es;
  lag_t    lag;
  proc_t   placed;
  node_t   enl_nxt;
  logic    es_nxt;
  lag_t    lag_nxt;
  proc_t   placed_nxt;
  alloc_t  free_slots;
  alloc_t  surplus;
  alloc_t  delta;
  lag_t    addend;
  logic [LagW:0]   lag_sum;
  logic [ProcW+1:0] want;
  logic    skip;
  proc_t   remaining;
  proc_t   assigned;
  result_t res;

  assign over      = (total_slots_r < {{(SlotsW-ProcW){1'b0}}, total_procs_r});
  assign blocked   = over && no_over_r;
  assign finished  = (placed_r >= total_procs_r);
  assign need_div  = !started_r && !blocked && !finished;
  assign slot_free = !out_valid_r || out_ready;
  assign pop       = (state_r == S_IDLE) && head.valid;

  assign div_req.start    = pop && need_div;
  assign div_req.dividend = total_procs_r;
  assign div_req.divisor  = (node_count_r == '0) ? node_t'(1) : node_count_r;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    if (started_r) begin
      avg    = avg_r;
      enl    = enl_r;
      es     = es_r;
      lag    = lag_r;
      placed = placed_r;
    end else begin
      avg    = (div_rsp.quotient == '0) ? proc_t'(1) : div_rsp.quotient;
      enl    = (div_rsp.quotient == '0) ? '0 : div_rsp.remainder;
      es     = (div_rsp.quotient != '0) && (div_rsp.remainder != '0);
      lag    = '0;
      placed = '0;
    end

    es_nxt  = es;
    enl_nxt = enl;
    if (es) begin
      if (enl == '0) begin
        es_nxt = 1'b0;
      end else begin
        enl_nxt = enl - 1'b1;
      end
    end

    free_slots = item_r.slots_allocated - item_r.slots_used;
    surplus    = free_slots - avg[AllocW-1:0];
    delta      = '0;
    addend     = '0;
    skip       = 1'b0;
    want       = '0;
    lag_nxt    = lag;

    if (over) begin
      want = {2'b00, avg} + (ProcW+2)'(es_nxt);
    end else if (item_r.slots_allocated <= item_r.slots_used) begin
      addend = {1'b0, avg};
      skip   = !es_nxt;
      want   = (ProcW+2)'(es_nxt);
    end else if ({{(ProcW-AllocW){1'b0}}, free_slots} < avg) begin
      addend = {1'b0, avg - {{(ProcW-AllocW){1'b0}}, free_slots}};
      want   = (ProcW+2)'(free_slots) + (ProcW+2)'(es_nxt);
    end else begin
      if (lag != '0) begin
        delta   = (lag < {{(LagW-AllocW){1'b0}}, surplus}) ? lag[AllocW-1:0] : surplus;
        lag_nxt = lag - {{(LagW-AllocW){1'b0}}, delta};
      end
      want = {2'b00, avg} + (ProcW+2)'(delta) + (ProcW+2)'(es_nxt);
    end

    lag_sum = {1'b0, lag} + {1'b0, addend};
    if (addend != '0) begin
      lag_nxt = lag_sum[LagW] ? LAG_MAX : lag_sum[LagW-1:0];
    end

    remaining  = total_procs_r - placed;
    assigned   = skip ? '0
               : ((want < {2'b00, remaining}) ? want[ProcW-1:0] : remaining);
    placed_nxt = placed + assigned;

    res.assigned_count      = assigned;
    res.node_oversubscribed = !skip &&
        ({{(ProcW+1-AllocW){1'b0}}, item_r.slots_allocated} <
         ({1'b0, item_r.procs_present} + {1'b0, assigned}));
    res.job_done            = !skip && (placed_nxt >= total_procs_r);
    res.status              = 1'b0;

    if (blocked) begin
      res = '{assigned_count: '0, node_oversubscribed: 1'b0, job_done: 1'b0, status: 1'b1};
    end else if (finished) begin
      res = '{assigned_count: '0, node_oversubscribed: 1'b0, job_done: 1'b1, status: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head.item;
    end
    if ((state_r == S_CALC) && slot_free) begin
      out_res_r <= res;
    end
    if (!rst_n) begin
      state_r       <= S_IDLE;
      total_procs_r <= proc_t'(1);
      node_count_r  <= node_t'(1);
      total_slots_r <= '0;
      no_over_r     <= 1'b0;
      started_r     <= 1'b0;
      avg_r         <= '0;
      enl_r         <= '0;
      es_r          <= 1'b0;
      lag_r         <= '0;
      placed_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TOTAL_PROCS:      total_procs_r <= cfg_data[ProcW-1:0];
          REG_NODE_COUNT:       node_count_r  <= cfg_data[NodeW-1:0];
          REG_TOTAL_SLOTS:      total_slots_r <= cfg_data;
          REG_NO_OVERSUBSCRIBE: no_over_r     <= cfg_data[0];
          default:              no_over_r     <= no_over_r;
        endcase
      end
      if ((state_r == S_CALC) && slot_free) begin
        out_valid_r <= 1'b1;
        if (!blocked && !finished) begin
          started_r <= 1'b1;
          avg_r     <= avg;
          enl_r     <= enl_nxt;
          es_r      <= es_nxt;
          lag_r     <= lag_nxt;
          placed_r  <= placed_nxt;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            state_r <= need_div ? S_DIV : S_CALC;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
